@@ sv/dos_pkg.sv @@
`default_nettype none

package dos_pkg;

	// queue geometry
	localparam int DEPTH = 8192;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// field widths
	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W  = 14;
	localparam int DROP_W   = 32;
	localparam int FUNC_W   = 2;

	// stream packing
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_FIELD_W = SAMPLE_W + 2 * LEVEL_W + DROP_W;
	localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

	// result buffer
	localparam int OUT_DEPTH = 3;
	localparam int OUT_PTR_W = 2;
	localparam int OUT_CNT_W = 2;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUSH      = 2'd0,
		FUNC_POP       = 2'd1,
		FUNC_FLUSH     = 2'd2,
		FUNC_FLUSH_CLR = 2'd3
	} func_t;

	// sample RAM access for one cycle
	typedef struct packed {
		logic                we;
		logic [PTR_W-1:0]    waddr;
		logic [SAMPLE_W-1:0] wdata;
		logic                re;
		logic [PTR_W-1:0]    raddr;
	} ram_req_t;

	// status that travels alongside the RAM read
	typedef struct packed {
		logic               pop_valid;
		logic [LEVEL_W-1:0] fill_level;
		logic [LEVEL_W-1:0] high_water;
		logic [DROP_W-1:0]  dropped_count;
		logic               chunk_done;
	} meta_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] popped_sample;
		logic                       pop_valid;
		logic [LEVEL_W-1:0]         fill_level;
		logic [LEVEL_W-1:0]         high_water;
		logic [DROP_W-1:0]          dropped_count;
		logic                       chunk_done;
	} result_t;

	// ring pointer step
	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		if (p == PTR_W'(DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + PTR_W'(1);
		end
		return n;
	endfunction

endpackage

`default_nettype wire

@@ sv/dos_ram.sv @@
`default_nettype none

module dos_ram #(
	parameter int DEPTH = 8192,
	parameter int WIDTH = 16,
	parameter int AW    = 13
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/dos_ctrl.sv @@
`default_nettype none

module dos_ctrl
	import dos_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_accept,
	input  wire func_t               func,
	input  wire logic [SAMPLE_W-1:0] sample,
	input  wire logic                last_in_chunk,
	output ram_req_t                 ram_req,
	output logic                     valid_s1,
	output meta_t                    meta_s1
);

	logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_nxt;
	logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_nxt;
	logic [CNT_W-1:0]  occ_q, occ_nxt;
	logic [CNT_W-1:0]  peak_q, peak_nxt;
	logic [DROP_W-1:0] drop_q, drop_nxt;
	logic              pop_ok;
	logic              full;

	assign full = (occ_q == CNT_W'(DEPTH));

	// next state and RAM access for the item at the input
	always_comb begin
		rd_ptr_nxt    = rd_ptr_q;
		wr_ptr_nxt    = wr_ptr_q;
		occ_nxt       = occ_q;
		peak_nxt      = peak_q;
		drop_nxt      = drop_q;
		pop_ok        = 1'b0;
		ram_req.we    = 1'b0;
		ram_req.waddr = wr_ptr_q;
		ram_req.wdata = sample;
		ram_req.re    = 1'b0;
		ram_req.raddr = rd_ptr_q;
		unique case (func)
			FUNC_PUSH: begin
				// full: oldest sample goes, level stays
				if (full) begin
					rd_ptr_nxt = next_ptr(rd_ptr_q);
					drop_nxt   = drop_q + DROP_W'(1);
				end else begin
					occ_nxt = occ_q + CNT_W'(1);
				end
				wr_ptr_nxt = next_ptr(wr_ptr_q);
				ram_req.we = in_accept;
				if (occ_nxt > peak_q) begin
					peak_nxt = occ_nxt;
				end
			end
			FUNC_POP: begin
				if (occ_q != '0) begin
					pop_ok     = 1'b1;
					ram_req.re = in_accept;
					rd_ptr_nxt = next_ptr(rd_ptr_q);
					occ_nxt    = occ_q - CNT_W'(1);
				end
			end
			FUNC_FLUSH, FUNC_FLUSH_CLR: begin
				rd_ptr_nxt = '0;
				wr_ptr_nxt = '0;
				occ_nxt    = '0;
				if (func == FUNC_FLUSH_CLR) begin
					peak_nxt = '0;
				end
			end
		endcase
	end

	// queue state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			occ_q    <= '0;
			peak_q   <= '0;
			drop_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_accept;
			if (in_accept) begin
				rd_ptr_q <= rd_ptr_nxt;
				wr_ptr_q <= wr_ptr_nxt;
				occ_q    <= occ_nxt;
				peak_q   <= peak_nxt;
				drop_q   <= drop_nxt;
			end
		end
	end

	// status travels with the RAM read
	always_ff @(posedge clk) begin
		if (in_accept) begin
			meta_s1.pop_valid     <= pop_ok;
			meta_s1.fill_level    <= LEVEL_W'(occ_nxt);
			meta_s1.high_water    <= LEVEL_W'(peak_nxt);
			meta_s1.dropped_count <= drop_nxt;
			meta_s1.chunk_done    <= last_in_chunk;
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(DEPTH))
		else $error("occupancy above depth");

	a_peak_cover: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= occ_q)
		else $error("high-water below fill level");

	a_drop_step: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && func == FUNC_PUSH && full) |=> drop_q == $past(drop_q) + DROP_W'(1))
		else $error("drop count did not advance on overwrite");

endmodule

`default_nettype wire

@@ sv/dos_out_fifo.sv @@
`default_nettype none

module dos_out_fifo
	import dos_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire result_t in_item,
	output logic         room,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_item
);

	result_t              buf_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_q;
	logic [OUT_PTR_W-1:0] rd_q;
	logic [OUT_CNT_W-1:0] count_q;
	logic                 pop;

	assign out_valid = (count_q != '0);
	assign out_item  = buf_q[rd_q];
	assign pop       = out_valid && out_ready;

	// space for one more item besides the one in flight; registered terms only
	assign room = ((OUT_CNT_W + 1)'(count_q) + (OUT_CNT_W + 1)'(in_valid))
		< (OUT_CNT_W + 1)'(OUT_DEPTH);

	always_ff @(posedge clk) begin
		if (in_valid) begin
			buf_q[wr_q] <= in_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (in_valid) begin
				wr_q <= (wr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_q + OUT_PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_q + OUT_PTR_W'(1);
			end
			if (in_valid && !pop) begin
				count_q <= count_q + OUT_CNT_W'(1);
			end else if (pop && !in_valid) begin
				count_q <= count_q - OUT_CNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_valid && !pop && count_q == OUT_CNT_W'(OUT_DEPTH)))
		else $error("result buffer overflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= OUT_CNT_W'(OUT_DEPTH))
		else $error("result buffer count out of range");

	a_room_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == OUT_CNT_W'(OUT_DEPTH)) |-> !room)
		else $error("room flagged while buffer full");

endmodule

`default_nettype wire

@@ sv/drop_oldest_sample_fifo.sv @@
// Drop-oldest sample queue: never refuses a push, overwrites the oldest sample when full.
// Input accept to result valid: registered sample RAM read, then a 3-entry result buffer.
// Throughput: one item per cycle while the result buffer has room; one result per item.
// Reset (arst_n low, asynchronous): pointers, fill level, high-water mark, drop count
// and result buffer cleared; sample RAM keeps its contents and needs no clearing pass.
`default_nettype none

module drop_oldest_sample_fifo
	import dos_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // [15:0] sample
	input  wire logic [FUNC_W-1:0]      s_tuser,  // [1:0] func
	input  wire logic                   s_tlast,  // last_in_chunk
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic      [OUT_TDATA_W-1:0] m_tdata,
	// [15:0] popped_sample, [29:16] fill_level, [43:30] high_water,
	// [75:44] dropped_count, [79:76] zero
	output logic                        m_tuser,  // pop_valid
	output logic                        m_tlast   // chunk_done
);

	ram_req_t            ram_req;
	logic [SAMPLE_W-1:0] rd_data;
	logic                valid_s1;
	meta_t               meta_s1;
	logic                in_accept;
	result_t             res_s1;
	result_t             res_out;

	assign in_accept = s_tvalid && s_tready;

	dos_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_accept    (in_accept),
		.func         (func_t'(s_tuser)),
		.sample       (s_tdata[SAMPLE_W-1:0]),
		.last_in_chunk(s_tlast),
		.ram_req      (ram_req),
		.valid_s1     (valid_s1),
		.meta_s1      (meta_s1)
	);

	dos_ram #(
		.DEPTH(DEPTH),
		.WIDTH(SAMPLE_W),
		.AW   (PTR_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.re   (ram_req.re),
		.raddr(ram_req.raddr),
		.rdata(rd_data)
	);

	// join RAM data with status; empty pop and non-pop give zero
	always_comb begin
		res_s1.popped_sample = meta_s1.pop_valid ? $signed(rd_data) : '0;
		res_s1.pop_valid     = meta_s1.pop_valid;
		res_s1.fill_level    = meta_s1.fill_level;
		res_s1.high_water    = meta_s1.high_water;
		res_s1.dropped_count = meta_s1.dropped_count;
		res_s1.chunk_done    = meta_s1.chunk_done;
	end

	dos_out_fifo u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_item  (res_s1),
		.room     (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_item (res_out)
	);

	assign m_tdata = {
		{OUT_PAD_W{1'b0}},
		res_out.dropped_count,
		res_out.high_water,
		res_out.fill_level,
		res_out.popped_sample
	};
	assign m_tuser = res_out.pop_valid;
	assign m_tlast = res_out.chunk_done;

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none

module testbench;
	import dos_pkg::*;

	localparam int RANDOM_ITEMS = 1150;
	localparam int FILL_DROPS   = 300;   // overwrites to collect while the queue is full
	localparam int DRAIN_CYCLES = 8;     // idle margin after the last result is back

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [FUNC_W-1:0]      s_tuser;
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;

	drop_oldest_sample_fifo dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [15:0] sample
		.s_tuser  (s_tuser),   // [1:0] func
		.s_tlast  (s_tlast),   // last_in_chunk
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [15:0] popped, [29:16] fill, [43:30] high water, [75:44] drops
		.m_tuser  (m_tuser),   // pop_valid
		.m_tlast  (m_tlast)    // chunk_done
	);

	// directed row: operation plus a hand-written result where it is obvious
	typedef struct packed {
		func_t              op;
		logic [15:0]        smp;
		logic               lst;
		logic               typed;
		logic [15:0]        e_smp;
		logic               e_vld;
		logic [LEVEL_W-1:0] e_fill;
		logic [LEVEL_W-1:0] e_hw;
	} dir_row_t;

	localparam int N_DIR = 19;

	dir_row_t dir_rows [N_DIR] = '{
		'{FUNC_POP,       16'h0000, 1'b1, 1'b1, 16'h0000, 1'b0, 14'd0, 14'd0},
		'{FUNC_PUSH,      16'h8000, 1'b0, 1'b1, 16'h0000, 1'b0, 14'd1, 14'd1},
		'{FUNC_PUSH,      16'h7fff, 1'b1, 1'b1, 16'h0000, 1'b0, 14'd2, 14'd2},
		'{FUNC_POP,       16'habcd, 1'b0, 1'b1, 16'h8000, 1'b1, 14'd1, 14'd2},
		'{FUNC_POP,       16'h5555, 1'b1, 1'b1, 16'h7fff, 1'b1, 14'd0, 14'd2},
		'{FUNC_POP,       16'hffff, 1'b0, 1'b1, 16'h0000, 1'b0, 14'd0, 14'd2},
		'{FUNC_PUSH,      16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0, 14'd1, 14'd2},
		'{FUNC_PUSH,      16'hffff, 1'b0, 1'b1, 16'h0000, 1'b0, 14'd2, 14'd2},
		'{FUNC_PUSH,      16'h0001, 1'b1, 1'b1, 16'h0000, 1'b0, 14'd3, 14'd3},
		'{FUNC_FLUSH,     16'h1234, 1'b0, 1'b1, 16'h0000, 1'b0, 14'd0, 14'd3},
		'{FUNC_POP,       16'h0000, 1'b0, 1'b1, 16'h0000, 1'b0, 14'd0, 14'd3},
		'{FUNC_PUSH,      16'hfffe, 1'b1, 1'b1, 16'h0000, 1'b0, 14'd1, 14'd3},
		'{FUNC_FLUSH_CLR, 16'h0000, 1'b1, 1'b1, 16'h0000, 1'b0, 14'd0, 14'd0},
		'{FUNC_PUSH,      16'h0002, 1'b0, 1'b1, 16'h0000, 1'b0, 14'd1, 14'd1},
		'{FUNC_PUSH,      16'h8001, 1'b1, 1'b0, 16'h0000, 1'b0, 14'd0, 14'd0},
		'{FUNC_POP,       16'hffff, 1'b1, 1'b1, 16'h0002, 1'b1, 14'd1, 14'd2},
		'{FUNC_FLUSH_CLR, 16'h7777, 1'b0, 1'b0, 16'h0000, 1'b0, 14'd0, 14'd0},
		'{FUNC_PUSH,      16'h7ffe, 1'b0, 1'b0, 16'h0000, 1'b0, 14'd0, 14'd0},
		'{FUNC_POP,       16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0, 14'd0, 14'd0}
	};

	// mirror of the queue contents and counters
	logic [15:0] mirror_store [DEPTH];
	int          mirror_rd;
	int          mirror_wr;
	int          mirror_fill;
	int          mirror_peak;
	logic [31:0] mirror_drops;

	result_t pending_results [$];
	int      err_count;
	bit      idle_on;

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// expected result of one queue operation; advances the mirror state
	function automatic result_t predict_queue_op(func_t op, logic [15:0] smp, logic lst);
		result_t r;
		r = '0;
		case (op)
			FUNC_PUSH: begin
				if (mirror_fill >= DEPTH) begin
					mirror_rd = (mirror_rd + 1) % DEPTH;
					mirror_fill--;
					mirror_drops++;
				end
				mirror_store[mirror_wr] = smp;
				mirror_wr = (mirror_wr + 1) % DEPTH;
				mirror_fill++;
				if (mirror_fill > mirror_peak) begin
					mirror_peak = mirror_fill;
				end
			end
			FUNC_POP: begin
				if (mirror_fill > 0) begin
					r.popped_sample = mirror_store[mirror_rd];
					r.pop_valid = 1'b1;
					mirror_rd = (mirror_rd + 1) % DEPTH;
					mirror_fill--;
				end
			end
			default: begin
				mirror_rd = 0;
				mirror_wr = 0;
				mirror_fill = 0;
				if (op == FUNC_FLUSH_CLR) begin
					mirror_peak = 0;
				end
			end
		endcase
		r.fill_level    = LEVEL_W'(mirror_fill);
		r.high_water    = LEVEL_W'(mirror_peak);
		r.dropped_count = mirror_drops;
		r.chunk_done    = lst;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			err_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endfunction

	// offer one item with a random gap in front when idle_on is set, wait until it is taken
	task automatic put_item(func_t op, logic [15:0] smp, logic lst, bit typed, result_t hand);
		int      gap;
		result_t predicted;
		gap = idle_on ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= smp;
		s_tlast  <= lst;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = predict_queue_op(op, smp, lst);
		pending_results.push_back(typed ? hand : predicted);
	endtask

	// sender holds off until every outstanding result is back
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// chunk of pushes with random samples, last marks the final one
	task automatic push_chunk(int len);
		for (int i = 0; i < len; i++) begin
			put_item(FUNC_PUSH, 16'($urandom), i == len - 1, 1'b0, '0);
		end
	endtask

	// run of pops, sample field carries junk that must be ignored
	task automatic pop_run(int len);
		for (int i = 0; i < len; i++) begin
			put_item(FUNC_POP, 16'($urandom), i == len - 1, 1'b0, '0);
		end
	endtask

	// stimulus
	initial begin
		result_t hand;
		int      sent;
		int      pick;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = FUNC_PUSH;
		s_tlast      = 1'b0;
		idle_on      = 1'b1;
		err_count    = 0;
		mirror_rd    = 0;
		mirror_wr    = 0;
		mirror_fill  = 0;
		mirror_peak  = 0;
		mirror_drops = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (dir_rows[i]) begin
			hand = '0;
			hand.popped_sample = dir_rows[i].e_smp;
			hand.pop_valid     = dir_rows[i].e_vld;
			hand.fill_level    = dir_rows[i].e_fill;
			hand.high_water    = dir_rows[i].e_hw;
			hand.chunk_done    = dir_rows[i].lst;
			put_item(dir_rows[i].op, dir_rows[i].smp, dir_rows[i].lst, dir_rows[i].typed, hand);
		end
		hold_until_drained();

		// fill past capacity so pushes start overwriting the oldest samples
		while (mirror_drops < FILL_DROPS) begin
			idle_on = ($urandom_range(0, 3) != 0);
			push_chunk($urandom_range(1, 64));
			if ($urandom_range(0, 9) == 0) begin
				pop_run($urandom_range(1, 4));
			end
		end
		hold_until_drained();

		// random mix of chunks, pop runs, flushes and noise
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			idle_on = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				pick = $urandom_range(1, 24);
				push_chunk(pick);
				sent += pick;
			end else if (pick < 85) begin
				pick = $urandom_range(1, 24);
				pop_run(pick);
				sent += pick;
			end else if (pick < 93) begin
				put_item(func_t'($urandom_range(0, 3)), 16'($urandom), 1'($urandom), 1'b0, '0);
				sent++;
			end else if (pick < 97) begin
				put_item(FUNC_FLUSH, 16'($urandom), 1'($urandom), 1'b0, '0);
				sent++;
			end else begin
				put_item(FUNC_FLUSH_CLR, 16'($urandom), 1'($urandom), 1'b0, '0);
				sent++;
			end
		end

		// drain and report
		hold_until_drained();
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// receiver: random stall before each result while idle_on is set
	initial begin
		int stall;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = idle_on ? $urandom_range(0, 5) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				err_count++;
				$display("%0t: unexpected result, expected none, actual %0h", $time, m_tdata);
			end else begin
				want = pending_results.pop_front();
				check_field("popped_sample", {16'h0, want.popped_sample}, {16'h0, m_tdata[15:0]});
				check_field("pop_valid", {31'h0, want.pop_valid}, {31'h0, m_tuser});
				check_field("fill_level", {18'h0, want.fill_level}, {18'h0, m_tdata[29:16]});
				check_field("high_water", {18'h0, want.high_water}, {18'h0, m_tdata[43:30]});
				check_field("dropped_count", want.dropped_count, m_tdata[75:44]);
				check_field("chunk_done", {31'h0, want.chunk_done}, {31'h0, m_tlast});
				check_field("tdata pad", 32'h0, {28'h0, m_tdata[79:76]});
			end
		end
	end

	// watchdog
	initial begin
		#8_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
sv/dos_pkg.sv
sv/dos_ram.sv
sv/dos_ctrl.sv
sv/dos_out_fifo.sv
sv/drop_oldest_sample_fifo.sv
sim/testbench.sv
